// ----- rtl/core/nes_pkg.sv -----
// shared types and constants of the note event to song text core
`timescale 1ns / 1ps
`default_nettype none
package nes_pkg;
	localparam int HELD_ENTRIES_DEF = 64;
	localparam int POSITION_BITS_DEF = 16;
	localparam int FIFO_DEPTH = 2;

	localparam logic [6:0] TEMPO_RESET = 7'd10;
	localparam logic [6:0] TEMPO_MIN = 7'd1;
	localparam logic [6:0] TEMPO_MAX = 7'd64;
	localparam logic [10:0] TICKS_MAX = 11'd1984;
	localparam logic [11:0] CHUNK = 12'd64;
	localparam logic [6:0] NOTE_LO = 7'h23;
	localparam logic [6:0] NOTE_HI = 7'h62;
	localparam logic [6:0] BYTE_BASE = 7'h3E;
	localparam logic [6:0] BYTE_QUOTE = 7'h27;
	localparam logic [6:0] BYTE_FULL = 7'h7E;
	localparam logic [6:0] BYTE_HOLD = 7'h3F;
	localparam logic [6:0] BYTE_CHAN = 7'h28;
	localparam logic [6:0] BYTE_NL = 7'h0A;
	localparam logic [6:0] KEY_OFS = 7'h1C;
	localparam logic [31:0] DUR_MAX = 32'd63;

	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_DELAY = 3'd1;
	localparam logic [2:0] REQ_NOTE_ON = 3'd2;
	localparam logic [2:0] REQ_NOTE_OFF = 3'd3;
	localparam logic [2:0] REQ_FINISH = 3'd4;

	typedef enum logic [2:0] {
		OP_START,
		OP_DELAY,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [3:0] chan;
		logic [6:0] key;
		logic [10:0] ticks;
		logic [6:0] hdr;
	} cmd_t;
endpackage
`default_nettype wire

// ----- rtl/core/note_event_to_song_text_core.sv -----
// top level of the note event to song text core
// an item reaches the back end through the command queue, then one byte is written per cycle
// while the output is not stalled; a note-off scans the held table with a read and a compare
// state per entry and shifts with a read and a write state per entry; a delay writes up to
// 62 bytes, one per cycle unless stalled; results leave through an output register
// asynchronous active-low reset clears all counters; the held table needs no clearing
`timescale 1ns / 1ps
`default_nettype none
module note_event_to_song_text_core #(
	parameter int HELD_ENTRIES = nes_pkg::HELD_ENTRIES_DEF,
	parameter int POSITION_BITS = nes_pkg::POSITION_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [6:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] req_type,
	input wire logic [3:0] channel,
	input wire logic [6:0] note,
	input wire logic [10:0] ticks,
	output logic out_valid,
	input wire logic out_ready,
	output logic [POSITION_BITS-1:0] position,
	output logic [6:0] out_byte,
	output logic is_patch,
	output logic last
);
	logic push, full, pop, q_valid;
	nes_pkg::cmd_t push_data, pop_data;

	nes_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .channel(channel), .note(note), .ticks(ticks),
		.push(push), .push_data(push_data), .full(full)
	);

	nes_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .valid(q_valid), .pop_data(pop_data)
	);

	nes_back #(
		.HELD_ENTRIES(HELD_ENTRIES),
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd(pop_data), .cmd_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.position(position), .out_byte(out_byte), .is_patch(is_patch), .last(last)
	);
endmodule
`default_nettype wire

// ----- rtl/core/nes_fifo.sv -----
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module nes_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire nes_pkg::cmd_t push_data,
	output logic full,
	input wire logic pop,
	output logic valid,
	output nes_pkg::cmd_t pop_data
);
	localparam int PW = (nes_pkg::FIFO_DEPTH > 1) ? $clog2(nes_pkg::FIFO_DEPTH) : 1;
	localparam int CW = $clog2(nes_pkg::FIFO_DEPTH + 1);

	nes_pkg::cmd_t mem_q [nes_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CW'(nes_pkg::FIFO_DEPTH));
	assign valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(nes_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(nes_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/nes_front.sv -----
// front end: tempo register, input classification and queue push
`timescale 1ns / 1ps
`default_nettype none
module nes_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [6:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] req_type,
	input wire logic [3:0] channel,
	input wire logic [6:0] note,
	input wire logic [10:0] ticks,
	output logic push,
	output nes_pkg::cmd_t push_data,
	input wire logic full
);
	logic [6:0] tempo_q;
	logic [6:0] tempo_c;
	logic keep;

	assign cfg_ready = 1'b1;
	assign in_ready = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= nes_pkg::TEMPO_RESET;
		end else if (cfg_valid) begin
			tempo_q <= cfg_data;
		end
	end

	always_comb begin
		tempo_c = tempo_q;
		if (tempo_q < nes_pkg::TEMPO_MIN) tempo_c = nes_pkg::TEMPO_MIN;
		if (tempo_q > nes_pkg::TEMPO_MAX) tempo_c = nes_pkg::TEMPO_MAX;
		push_data.chan = channel;
		push_data.key = note;
		push_data.ticks = (ticks > nes_pkg::TICKS_MAX) ? nes_pkg::TICKS_MAX : ticks;
		push_data.hdr = 7'(nes_pkg::BYTE_BASE + tempo_c);
		push_data.op = nes_pkg::OP_START;
		keep = 1'b1;
		case (req_type)
			nes_pkg::REQ_START: push_data.op = nes_pkg::OP_START;
			nes_pkg::REQ_DELAY: push_data.op = nes_pkg::OP_DELAY;
			nes_pkg::REQ_NOTE_ON: begin
				push_data.op = nes_pkg::OP_NOTE_ON;
				// notes outside the playable range cause nothing
				keep = (note >= nes_pkg::NOTE_LO) && (note <= nes_pkg::NOTE_HI);
			end
			nes_pkg::REQ_NOTE_OFF: push_data.op = nes_pkg::OP_NOTE_OFF;
			nes_pkg::REQ_FINISH: push_data.op = nes_pkg::OP_FINISH;
			default: keep = 1'b0;
		endcase
	end

	assign push = in_valid && in_ready && keep;
endmodule
`default_nettype wire

// ----- rtl/core/nes_back.sv -----
// back end: song state, held note table and byte writer
`timescale 1ns / 1ps
`default_nettype none
module nes_back #(
	parameter int HELD_ENTRIES = nes_pkg::HELD_ENTRIES_DEF,
	parameter int POSITION_BITS = nes_pkg::POSITION_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire nes_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [POSITION_BITS-1:0] position,
	output logic [6:0] out_byte,
	output logic is_patch,
	output logic last
);
	localparam int IW = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
	localparam int CW = $clog2(HELD_ENTRIES + 1);
	localparam int EW = 4 + 7 + POSITION_BITS + 32;

	typedef enum logic [3:0] {
		S_IDLE, S_HDR, S_CHUNK_A, S_CHUNK_B, S_FLUSH_A, S_FLUSH_B, S_NL,
		S_NOTE_A, S_NOTE_B, S_NOTE_C, S_RD, S_CMP, S_PATCH, S_SH_RD, S_SH_WR
	} state_t;

	state_t state_q;
	nes_pkg::cmd_t cmd_q;
	logic [CW-1:0] held_count_q, idx_q;
	logic [11:0] pend_q;
	logic [31:0] song_q;
	logic [POSITION_BITS-1:0] wp_q;
	logic [EW-1:0] mem [HELD_ENTRIES];
	logic [EW-1:0] rd_q;

	logic out_free;
	logic emit;
	logic [POSITION_BITS-1:0] e_pos;
	logic [6:0] e_byte;
	logic e_patch, e_last;
	logic rd_en, wr_en;
	logic [CW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data;
	logic [31:0] diff;
	logic match;
	logic [CW-1:0] idx_nx;

	assign out_free = !out_valid || out_ready;
	assign diff = song_q - rd_q[31:0];
	assign match = (rd_q[EW-1 -: 4] == cmd_q.chan) && (rd_q[EW-5 -: 7] == cmd_q.key);
	assign idx_nx = idx_q + 1'b1;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	// byte to write in each emitting state
	always_comb begin
		emit = 1'b0;
		e_pos = wp_q;
		e_byte = nes_pkg::BYTE_NL;
		e_patch = 1'b0;
		e_last = 1'b0;
		case (state_q)
			S_HDR: begin
				emit = 1'b1; e_byte = cmd_q.hdr; e_last = 1'b1;
			end
			S_CHUNK_A: begin
				emit = (pend_q > nes_pkg::CHUNK); e_byte = nes_pkg::BYTE_QUOTE;
			end
			S_CHUNK_B: begin
				emit = 1'b1; e_byte = nes_pkg::BYTE_FULL;
				e_last = ((pend_q - nes_pkg::CHUNK) <= nes_pkg::CHUNK);
			end
			S_FLUSH_A: begin
				emit = 1'b1; e_byte = nes_pkg::BYTE_QUOTE;
			end
			S_FLUSH_B: begin
				emit = 1'b1; e_byte = 7'(nes_pkg::BYTE_BASE + pend_q[6:0]);
			end
			S_NL: begin
				emit = 1'b1; e_byte = nes_pkg::BYTE_NL; e_last = 1'b1;
			end
			S_NOTE_A: begin
				emit = 1'b1; e_byte = 7'(nes_pkg::BYTE_CHAN + {3'b000, cmd_q.chan});
			end
			S_NOTE_B: begin
				emit = 1'b1; e_byte = 7'(cmd_q.key + nes_pkg::KEY_OFS);
			end
			S_NOTE_C: begin
				emit = 1'b1; e_byte = nes_pkg::BYTE_HOLD; e_last = 1'b1;
			end
			S_PATCH: begin
				emit = 1'b1;
				e_pos = rd_q[32 +: POSITION_BITS];
				e_byte = (diff > nes_pkg::DUR_MAX) ? nes_pkg::BYTE_FULL
					: 7'(nes_pkg::BYTE_HOLD + {1'b0, diff[5:0]});
				e_patch = 1'b1;
				e_last = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_comb begin
		rd_en = (state_q == S_RD) || (state_q == S_SH_RD);
		rd_addr = (state_q == S_SH_RD) ? idx_nx : idx_q;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		if (state_q == S_NOTE_C && out_free && held_count_q < CW'(HELD_ENTRIES)) begin
			wr_en = 1'b1;
			wr_addr = held_count_q;
			wr_data = {cmd_q.chan, cmd_q.key, wp_q, song_q};
		end else if (state_q == S_SH_WR) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			held_count_q <= '0;
			idx_q <= '0;
			pend_q <= '0;
			song_q <= '0;
			wp_q <= '0;
			out_valid <= 1'b0;
			position <= '0;
			out_byte <= '0;
			is_patch <= 1'b0;
			last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (emit && out_free) begin
				out_valid <= 1'b1;
				position <= e_pos;
				out_byte <= e_byte;
				is_patch <= e_patch;
				last <= e_last;
				if (!e_patch) wp_q <= wp_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						idx_q <= '0;
						case (cmd.op)
							nes_pkg::OP_START: begin
								held_count_q <= '0;
								pend_q <= '0;
								song_q <= '0;
								wp_q <= '0;
								state_q <= S_HDR;
							end
							nes_pkg::OP_DELAY: begin
								pend_q <= pend_q + {1'b0, cmd.ticks};
								song_q <= song_q + {21'd0, cmd.ticks};
								state_q <= S_CHUNK_A;
							end
							nes_pkg::OP_NOTE_ON:
								state_q <= (pend_q != '0) ? S_FLUSH_A : S_NOTE_A;
							nes_pkg::OP_NOTE_OFF:
								state_q <= (held_count_q != '0) ? S_RD : S_IDLE;
							nes_pkg::OP_FINISH:
								state_q <= (pend_q != '0) ? S_FLUSH_A : S_NL;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_HDR: if (out_free) state_q <= S_IDLE;
				S_CHUNK_A: begin
					if (pend_q <= nes_pkg::CHUNK) state_q <= S_IDLE;
					else if (out_free) state_q <= S_CHUNK_B;
				end
				S_CHUNK_B: begin
					if (out_free) begin
						pend_q <= pend_q - nes_pkg::CHUNK;
						state_q <= S_CHUNK_A;
					end
				end
				S_FLUSH_A: if (out_free) state_q <= S_FLUSH_B;
				S_FLUSH_B: begin
					if (out_free) begin
						pend_q <= '0;
						state_q <= (cmd_q.op == nes_pkg::OP_NOTE_ON) ? S_NOTE_A : S_NL;
					end
				end
				S_NL: if (out_free) state_q <= S_IDLE;
				S_NOTE_A: if (out_free) state_q <= S_NOTE_B;
				S_NOTE_B: if (out_free) state_q <= S_NOTE_C;
				S_NOTE_C: begin
					if (out_free) begin
						if (held_count_q < CW'(HELD_ENTRIES)) held_count_q <= held_count_q + 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (match) state_q <= S_PATCH;
					else begin
						idx_q <= idx_nx;
						state_q <= (idx_nx < held_count_q) ? S_RD : S_IDLE;
					end
				end
				S_PATCH: begin
					if (out_free) begin
						if (idx_nx < held_count_q) state_q <= S_SH_RD;
						else begin
							held_count_q <= held_count_q - 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				S_SH_WR: begin
					// close the gap left by the removed entry
					idx_q <= idx_nx;
					if ((idx_nx + 1'b1) < held_count_q) state_q <= S_SH_RD;
					else begin
						held_count_q <= held_count_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CW'(HELD_ENTRIES))
		else $error("held count above table size");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pend_q <= nes_pkg::CHUNK))
		else $error("pending delay left above one chunk");
	a_patch_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_patch) |-> last)
		else $error("patch not final write of its item");
	a_wp_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP || state_q == S_SH_WR) |=> $stable(wp_q))
		else $error("write position moved during table search");
endmodule
`default_nettype wire
